### src/ggs_pkg.sv
// Package for the go-to-goal steering block: shared types, constants and the
// arctangent table of the CORDIC cells. No dependencies.
package ggs_pkg;

  // Fixed angles in Q4.12 and Q3.30 radians.
  localparam logic signed [16:0] PI_Q12      = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

  // Square root of a 34 bit radicand, two radicand bits per step.
  localparam int SQRT_STEPS = 17;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GOAL_X           = 3'd0,
    CFG_GOAL_Y           = 3'd1,
    CFG_HEADING_DEADBAND = 3'd2,
    CFG_ARRIVAL_RADIUS   = 3'd3,
    CFG_SPEED_GAIN       = 3'd4
  } cfg_idx_t;

  // Data carried along the row of cells.
  typedef struct packed {
    logic        [33:0] sq_n;  // radicand, consumed two bits per step from the top
    logic        [19:0] rem;   // square root partial remainder
    logic        [16:0] root;  // square root partial result (distance when done)
    logic signed [31:0] x;     // CORDIC vector
    logic signed [31:0] y;
    logic signed [33:0] z;     // accumulated angle, 2^-30 rad
    logic               zero;  // offset to goal is zero
    logic signed [14:0] head;  // heading of the pose
  } pipe_t;

  // atan(2^-i) in units of 2^-30 rad, truncated.
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] a;
    case (i)
      0:       a = 34'sd843314856;
      1:       a = 34'sd497837829;
      2:       a = 34'sd263043836;
      3:       a = 34'sd133525158;
      4:       a = 34'sd67021686;
      5:       a = 34'sd33543515;
      6:       a = 34'sd16775850;
      7:       a = 34'sd8388437;
      8:       a = 34'sd4194282;
      9:       a = 34'sd2097149;
      10:      a = 34'sd1048575;
      11:      a = 34'sd524287;
      12:      a = 34'sd262143;
      13:      a = 34'sd131071;
      14:      a = 34'sd65535;
      15:      a = 34'sd32767;
      16:      a = 34'sd16383;
      17:      a = 34'sd8191;
      18:      a = 34'sd4095;
      19:      a = 34'sd2047;
      20:      a = 34'sd1023;
      21:      a = 34'sd511;
      22:      a = 34'sd255;
      23:      a = 34'sd127;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

### src/go_to_goal_steering_top.sv
// Top level of the go-to-goal steering block: configuration registers and the
// pipeline of front end, row of cells and back end. Depends on ggs_pkg and its modules.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid / in_ready       pos_x, pos_y, heading
//   output   out        out_valid / out_ready     turn_rate, forward_speed
//   config   in         cfg_write (no wait)       cfg_index, cfg_data
//
// One pose transaction is accepted and one command transaction is delivered
// per cycle while out_ready holds. A pose passes the front end registers, the
// row of cells and the back end registers; each cell does one square root
// digit, one CORDIC rotation or both, as its place in the row allows.
// Reset (rst, synchronous) clears every valid bit and loads the register
// defaults: goal (10.0 m, 1.0 m), deadband 20, radius 26, gain 51.
// Every stage holds only while it is full and the stage after it stalls, so
// bubbles close up and input is still taken while a result waits on out_ready.
module go_to_goal_steering_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic        [2:0]   cfg_index,
  input  logic        [15:0]  cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic signed [14:0]  heading,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [14:0]  turn_rate,
  output logic        [14:0]  forward_speed
);

  // The row is as long as the longer of the two iterations.
  localparam int N_CELLS = (CORDIC_STAGES > ggs_pkg::SQRT_STEPS) ?
                           CORDIC_STAGES : ggs_pkg::SQRT_STEPS;

  // Configuration registers.
  logic signed [15:0] goal_x;
  logic signed [15:0] goal_y;
  logic        [11:0] heading_deadband;
  logic        [14:0] arrival_radius;
  logic        [7:0]  speed_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x           <= 16'sd2560;
      goal_y           <= 16'sd256;
      heading_deadband <= 12'd20;
      arrival_radius   <= 15'd26;
      speed_gain       <= 8'd51;
    end else if (cfg_write) begin
      case (ggs_pkg::cfg_idx_t'(cfg_index))
        ggs_pkg::CFG_GOAL_X:           goal_x           <= cfg_data;
        ggs_pkg::CFG_GOAL_Y:           goal_y           <= cfg_data;
        ggs_pkg::CFG_HEADING_DEADBAND: heading_deadband <= cfg_data[11:0];
        ggs_pkg::CFG_ARRIVAL_RADIUS:   arrival_radius   <= cfg_data[14:0];
        ggs_pkg::CFG_SPEED_GAIN:       speed_gain       <= cfg_data[7:0];
        default: ;  // unknown index: the write is dropped
      endcase
    end
  end

  // Chain links: link g feeds cell g, link N_CELLS feeds the back end.
  ggs_pkg::pipe_t       link_pipe [0:N_CELLS];
  logic [N_CELLS:0]     link_valid;
  logic [N_CELLS:0]     link_ready;

  ggs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .goal_x     (goal_x),
    .goal_y     (goal_y),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .heading    (heading),
    .out_valid  (link_valid[0]),
    .out_pipe   (link_pipe[0]),
    .down_ready (link_ready[0])
  );

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    ggs_cell #(
      .IDX           (g),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (link_valid[g]),
      .up_ready   (link_ready[g]),
      .in_pipe    (link_pipe[g]),
      .out_valid  (link_valid[g+1]),
      .out_pipe   (link_pipe[g+1]),
      .down_ready (link_ready[g+1])
    );
  end

  ggs_back u_back (
    .clk              (clk),
    .rst              (rst),
    .heading_deadband (heading_deadband),
    .arrival_radius   (arrival_radius),
    .speed_gain       (speed_gain),
    .in_valid         (link_valid[N_CELLS]),
    .up_ready         (link_ready[N_CELLS]),
    .in_pipe          (link_pipe[N_CELLS]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .turn_rate        (turn_rate),
    .forward_speed    (forward_speed)
  );

  // The wrapped bearing error always lies within one half turn.
  a_turn_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (turn_rate >= -15'sd12868 && turn_rate <= 15'sd12868))
    else $error("turn rate outside -pi..pi");

  // Input is only refused when the output is held up and the whole pipe is full.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && (&link_valid)))
    else $error("input stalled without a full pipeline");

  // Reset leaves no command transaction pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

### src/ggs_front.sv
// Front end of the steering pipeline: goal offset, squares, CORDIC quadrant
// pre-rotation and the sum of squares. Depends on ggs_pkg.
module ggs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic signed [15:0]    goal_x,
  input  logic signed [15:0]    goal_y,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    pos_x,
  input  logic signed [15:0]    pos_y,
  input  logic signed [14:0]    heading,
  output logic                  out_valid,
  output ggs_pkg::pipe_t        out_pipe,
  input  logic                  down_ready
);

  // Stage 1: offset to the goal.
  logic               v1;
  logic signed [16:0] dx, dy;
  logic signed [14:0] head1;
  // Stage 2: squares and pre-rotated vector.
  logic               v2;
  logic        [32:0] sqx, sqy;
  logic signed [31:0] x2, y2;
  logic signed [33:0] z2;
  logic               zero2;
  logic signed [14:0] head2;

  logic               en1, en2, en3;
  logic signed [33:0] dx_sq, dy_sq;
  logic signed [31:0] xs, ys, x_next, y_next;
  logic signed [33:0] z_next;

  assign en3      = !out_valid || down_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  always_comb begin
    xs = {{3{dx[16]}}, dx, 12'd0};
    ys = {{3{dy[16]}}, dy, 12'd0};
    x_next = xs;
    y_next = ys;
    z_next = '0;
    // Bring a vector in the left half plane into the right one.
    if (dx < 0) begin
      if (dy >= 0) begin
        x_next = ys;
        y_next = -xs;
        z_next = ggs_pkg::HALF_PI_Q30;
      end else begin
        x_next = -ys;
        y_next = xs;
        z_next = -ggs_pkg::HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dx    <= {goal_x[15], goal_x} - {pos_x[15], pos_x};
      dy    <= {goal_y[15], goal_y} - {pos_y[15], pos_y};
      head1 <= heading;
    end
    if (en2) begin
      sqx   <= dx_sq[32:0];
      sqy   <= dy_sq[32:0];
      x2    <= x_next;
      y2    <= y_next;
      z2    <= z_next;
      zero2 <= (dx == 0) && (dy == 0);
      head2 <= head1;
    end
    if (en3) begin
      out_pipe.sq_n <= {1'b0, sqx} + {1'b0, sqy};
      out_pipe.rem  <= '0;
      out_pipe.root <= '0;
      out_pipe.x    <= x2;
      out_pipe.y    <= y2;
      out_pipe.z    <= z2;
      out_pipe.zero <= zero2;
      out_pipe.head <= head2;
    end
  end

endmodule

### src/ggs_cell.sv
// One cell of the steering pipeline: a square root digit step and a CORDIC
// vectoring step, each enabled by the cell's place in the row. Depends on ggs_pkg.
module ggs_cell #(
  parameter int IDX           = 0,
  parameter int CORDIC_STAGES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           up_ready,
  input  ggs_pkg::pipe_t in_pipe,
  output logic           out_valid,
  output ggs_pkg::pipe_t out_pipe,
  input  logic           down_ready
);

  localparam bit DO_SQRT   = IDX < ggs_pkg::SQRT_STEPS;
  localparam bit DO_CORDIC = IDX < CORDIC_STAGES;
  localparam int SH        = DO_CORDIC ? IDX : 0;

  logic               en;
  logic        [19:0] rem_sh, trial;
  logic signed [31:0] xs, ys;
  logic signed [33:0] ang;
  ggs_pkg::pipe_t     nxt;

  assign en       = !out_valid || down_ready;
  assign up_ready = en;

  always_comb begin
    nxt    = in_pipe;
    rem_sh = {in_pipe.rem[17:0], in_pipe.sq_n[33:32]};
    trial  = {1'b0, in_pipe.root, 2'b01};
    xs     = in_pipe.x >>> SH;
    ys     = in_pipe.y >>> SH;
    ang    = ggs_pkg::atan_q30(SH);
    if (DO_SQRT) begin
      nxt.sq_n = {in_pipe.sq_n[31:0], 2'b00};
      if (rem_sh >= trial) begin
        nxt.rem  = rem_sh - trial;
        nxt.root = {in_pipe.root[15:0], 1'b1};
      end else begin
        nxt.rem  = rem_sh;
        nxt.root = {in_pipe.root[15:0], 1'b0};
      end
    end
    if (DO_CORDIC) begin
      if (in_pipe.y > 0) begin
        nxt.x = in_pipe.x + ys;
        nxt.y = in_pipe.y - xs;
        nxt.z = in_pipe.z + ang;
      end else begin
        nxt.x = in_pipe.x - ys;
        nxt.y = in_pipe.y + xs;
        nxt.z = in_pipe.z - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pipe <= nxt;
    end
  end

  // The square root remainder never exceeds twice the partial root.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({2'b00, out_pipe.rem} <= {4'd0, out_pipe.root, 1'b0}))
    else $error("square root remainder out of bound");

endmodule

### src/ggs_back.sv
// Back end of the steering pipeline: angle rounding, bearing error, wrap,
// arrival and deadband tests, speed product and the output register. Depends on ggs_pkg.
module ggs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic        [11:0]    heading_deadband,
  input  logic        [14:0]    arrival_radius,
  input  logic        [7:0]     speed_gain,
  input  logic                  in_valid,
  output logic                  up_ready,
  input  ggs_pkg::pipe_t        in_pipe,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [14:0]    turn_rate,
  output logic        [14:0]    forward_speed
);

  logic               v1;
  logic signed [16:0] err_raw;
  logic               arrived;
  logic        [24:0] prod;

  logic               en1, en2;
  logic signed [33:0] z_rnd;
  logic signed [15:0] bearing;
  logic signed [16:0] e1, e2, mag;
  logic        [16:0] spd;
  logic        [14:0] spd_sat;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign up_ready = en1;

  // Round the angle to Q3.12: add half an LSB, shift down 18.
  assign z_rnd   = in_pipe.z + 34'sd131072;
  assign bearing = in_pipe.zero ? 16'sd0 : z_rnd[33:18];

  always_comb begin
    e1 = err_raw;
    if (e1 < -ggs_pkg::PI_Q12) e1 = e1 + ggs_pkg::TWO_PI_Q12;
    e2 = e1;
    if (e2 > ggs_pkg::PI_Q12) e2 = e2 - ggs_pkg::TWO_PI_Q12;
    mag     = (e2 < 0) ? -e2 : e2;
    spd     = prod[24:8];
    spd_sat = (spd > 17'd32767) ? 15'h7FFF : spd[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      err_raw <= {bearing[15], bearing} - {{2{in_pipe.head[14]}}, in_pipe.head};
      arrived <= in_pipe.root < {2'b00, arrival_radius};
      prod    <= {8'd0, in_pipe.root} * {17'd0, speed_gain};
    end
    if (en2) begin
      if (arrived) begin
        turn_rate     <= '0;
        forward_speed <= '0;
      end else begin
        turn_rate     <= e2[14:0];
        forward_speed <= (mag > {5'd0, heading_deadband}) ? 15'd0 : spd_sat;
      end
    end
  end

endmodule
